/* rtl/joint_setpoint_slew_interpolator_unit_assert.svh */
// Assertion macros for the joint setpoint slew interpolator.
`ifndef JOINT_SETPOINT_SLEW_INTERPOLATOR_UNIT_ASSERT_SVH
`define JOINT_SETPOINT_SLEW_INTERPOLATOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define JSSI_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JSSI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/jssi_pkg.sv */
package jssi_pkg;

    localparam int JOINT_NUM_DEF = 1;
    localparam int STEPS_PER_REV_DEF = 3200;

    localparam logic signed [21:0] Q_TWO_PI  = 22'sd411775;
    localparam logic signed [21:0] Q_FOUR_PI = 22'sd823550;
    localparam logic signed [21:0] Q_PI      = 22'sd205887;
    localparam logic signed [21:0] A_MAX     = 22'sd1048575;
    localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;
    localparam logic [21:0] SNAP_ZERO  = 22'd65;
    localparam logic [21:0] SEND_BAND  = 22'd655;
    localparam logic [15:0] TOL_FLOOR  = 16'd66;
    localparam logic [21:0] Q_SAT      = 22'd1048576;
    localparam logic [23:0] PULSE_MAX  = 24'hFFFFFF;

    localparam int NUM_W = 59;
    localparam int DEN_W = 32;
    localparam int QUO_W = 25;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] REQ_TARGET   = 2'd0;
    localparam logic [1:0] REQ_FEEDBACK = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;

    localparam logic KIND_CMD    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [2:0] CFG_GEAR      = 3'd0;
    localparam logic [2:0] CFG_MREV      = 3'd1;
    localparam logic [2:0] CFG_AXNEG     = 3'd2;
    localparam logic [2:0] CFG_BIPOLAR   = 3'd3;
    localparam logic [2:0] CFG_LIMIT_LO  = 3'd4;
    localparam logic [2:0] CFG_LIMIT_HI  = 3'd5;
    localparam logic [2:0] CFG_MAX_STEP  = 3'd6;
    localparam logic [2:0] CFG_TOLERANCE = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_CANON,
        ST_T_CHECK,
        ST_F_DEN,
        ST_F_MUL,
        ST_F_NUM,
        ST_K_ERR,
        ST_K_MOVE,
        ST_K_LIM,
        ST_K_SNAP,
        ST_K_BAND,
        ST_P_MUL,
        ST_P_NUM,
        ST_DIV_GO,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [7:0]         gear;
        logic               mrev;
        logic               axneg;
        logic               bip;
        logic signed [20:0] lo;
        logic signed [20:0] hi;
        logic [15:0]        step_limit;
        logic [15:0]        tol;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [20:0] target;
        logic signed [31:0] count;
        logic               sign;
    } in_t;

    typedef struct packed {
        logic               kind;
        logic [23:0]        pulse;
        logic               dir;
        logic signed [20:0] angle;
    } res_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    // Truncating remainder by 2*pi, then fold into (-pi, pi].
    function automatic logic signed [21:0] wrap_pi(input logic signed [21:0] a);
        logic signed [21:0] r;
        if (a >= Q_FOUR_PI)
            r = a - Q_FOUR_PI;
        else if (a >= Q_TWO_PI)
            r = a - Q_TWO_PI;
        else if (a <= -Q_FOUR_PI)
            r = a + Q_FOUR_PI;
        else if (a <= -Q_TWO_PI)
            r = a + Q_TWO_PI;
        else
            r = a;
        if (r > Q_PI)
            r = r - Q_TWO_PI;
        else if (r <= -Q_PI)
            r = r + Q_TWO_PI;
        return r;
    endfunction

    function automatic logic [21:0] abs22(input logic signed [21:0] a);
        return a[21] ? 22'(-a) : 22'(a);
    endfunction

endpackage

/* rtl/joint_setpoint_slew_interpolator_unit.sv */
// Setpoint slew interpolator for one stepper joint.
// Input stream (s_axis_*): tuser carries the request type (new target, motor position
// feedback, command tick); tdata carries the target angle, the feedback count and the
// feedback sign byte bit. Output stream (m_axis_*): tuser says whether the transfer is a
// motor command or a position report; tdata carries joint number, pulse count,
// direction and the reported angle.
// Configuration (cfg_*) is always ready and must be written while the block is idle.
// One item is taken at a time. A target gives no result. Feedback items and ticks use the
// 59-step bit-serial divider shared by the angle conversion and the pulse conversion; a
// tick with no move armed or no feedback yet, or one that sends nothing, gives no result.
// Results wait in an output register, so the next item is taken while the last result
// is still stalled; a second result then holds the sequencer until the first transfer.
// Reset clears all joint state (goal, command, last sent, measured angle, armed and
// feedback flags) and restores the configuration defaults; no clearing pass is needed.
module joint_setpoint_slew_interpolator_unit #(
    parameter int JOINT_NUM     = jssi_pkg::JOINT_NUM_DEF,
    parameter int STEPS_PER_REV = jssi_pkg::STEPS_PER_REV_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // target_angle[20:0], feedback_count[52:21],
                                       // feedback_sign[53], zero[55:54]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // joint_number[2:0], pulse_count[26:3],
                                       // motor_direction[27], reported_angle[48:28],
                                       // zero[55:49]
    output logic [0:0]  m_axis_tuser,  // result_kind[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    jssi_pkg::cfg_t     cfg;
    jssi_pkg::in_t      in_item;
    jssi_pkg::res_t     res;
    jssi_pkg::res_t     out_reg;
    jssi_pkg::div_rsp_t div_rsp;
    logic               res_valid, res_ready;
    logic               out_valid_reg;
    logic               div_start;
    logic [jssi_pkg::NUM_W-1:0] div_dividend;
    logic [jssi_pkg::DEN_W-1:0] div_divisor;

    assign in_item.req_type = s_axis_tuser;
    assign in_item.target   = $signed(s_axis_tdata[20:0]);
    assign in_item.count    = $signed(s_axis_tdata[52:21]);
    assign in_item.sign     = s_axis_tdata[53];

    jssi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jssi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp)
    );

    jssi_ctrl #(
        .STEPS_PER_REV (STEPS_PER_REV)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_item      (in_item),
        .cfg          (cfg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_rsp      (div_rsp)
    );

    // hold a result until its transfer, load the next one as the slot frees
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {7'd0, out_reg.angle, out_reg.dir, out_reg.pulse, 3'(JOINT_NUM)};

endmodule

/* rtl/jssi_cfg.sv */
module jssi_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [20:0]        cfg_data,
    output jssi_pkg::cfg_t     cfg
);

    jssi_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gear       <= 8'd30;
            cfg_reg.mrev       <= 1'b0;
            cfg_reg.axneg      <= 1'b1;
            cfg_reg.bip        <= 1'b0;
            cfg_reg.lo         <= -21'sd406323;
            cfg_reg.hi         <= 21'sd0;
            cfg_reg.step_limit <= 16'd1049;
            cfg_reg.tol        <= 16'd655;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                jssi_pkg::CFG_GEAR:      cfg_reg.gear       <= cfg_data[7:0];
                jssi_pkg::CFG_MREV:      cfg_reg.mrev       <= cfg_data[0];
                jssi_pkg::CFG_AXNEG:     cfg_reg.axneg      <= cfg_data[0];
                jssi_pkg::CFG_BIPOLAR:   cfg_reg.bip        <= cfg_data[0];
                jssi_pkg::CFG_LIMIT_LO:  cfg_reg.lo         <= $signed(cfg_data);
                jssi_pkg::CFG_LIMIT_HI:  cfg_reg.hi         <= $signed(cfg_data);
                jssi_pkg::CFG_MAX_STEP:  cfg_reg.step_limit <= cfg_data[15:0];
                jssi_pkg::CFG_TOLERANCE: cfg_reg.tol        <= cfg_data[15:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

/* rtl/jssi_div.sv */
module jssi_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [jssi_pkg::NUM_W-1:0]  dividend,
    input  logic [jssi_pkg::DEN_W-1:0]  divisor,
    output jssi_pkg::div_rsp_t          rsp
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [jssi_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [jssi_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [jssi_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [jssi_pkg::DEN_W-1:0]  dsr_reg, dsr_next;
    logic [jssi_pkg::QUO_W-1:0]  quo_reg, quo_next;
    logic                        ovf_reg, ovf_next;
    logic [jssi_pkg::DEN_W:0]    rem_sh;
    logic [jssi_pkg::DEN_W:0]    rem_sub;
    logic                        ge;

    assign rem_sh  = {rem_reg, num_reg[jssi_pkg::NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            // one quotient bit a cycle; flag any bit that falls off the top
            num_next = {num_reg[jssi_pkg::NUM_W-2:0], 1'b0};
            rem_next = ge ? rem_sub[jssi_pkg::DEN_W-1:0] : rem_sh[jssi_pkg::DEN_W-1:0];
            quo_next = {quo_reg[jssi_pkg::QUO_W-2:0], ge};
            ovf_next = ovf_reg | quo_reg[jssi_pkg::QUO_W-1];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == jssi_pkg::CNT_W'(jssi_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* rtl/jssi_ctrl.sv */
module jssi_ctrl #(
    parameter int STEPS_PER_REV = jssi_pkg::STEPS_PER_REV_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  jssi_pkg::in_t               in_item,
    input  jssi_pkg::cfg_t              cfg,
    output logic                        res_valid,
    input  logic                        res_ready,
    output jssi_pkg::res_t              res,
    output logic                        div_start,
    output logic [jssi_pkg::NUM_W-1:0]  div_dividend,
    output logic [jssi_pkg::DEN_W-1:0]  div_divisor,
    input  jssi_pkg::div_rsp_t          div_rsp
);

    localparam logic [15:0] SPR = 16'(STEPS_PER_REV);

    jssi_pkg::state_t state_reg, state_next;

    logic signed [20:0] goal_reg, goal_next;
    logic signed [20:0] cmd_reg, cmd_next;
    logic signed [20:0] last_reg, last_next;
    logic signed [20:0] meas_reg, meas_next;
    logic               armed_reg, armed_next;
    logic               seen_reg, seen_next;

    logic signed [21:0] a_reg, a_next;
    logic signed [21:0] err_reg, err_next;
    logic               neg_reg, neg_next;
    logic               sign_reg, sign_next;
    logic               pulse_reg, pulse_next;
    logic               dir_reg, dir_next;
    logic [31:0]        mag_reg, mag_next;
    logic [jssi_pkg::DEN_W-1:0] den_reg, den_next;
    logic [jssi_pkg::NUM_W-1:0] num_reg, num_next;
    jssi_pkg::res_t     res_reg, res_next;

    logic [31:0]        mul_a;
    logic [26:0]        mul_b;
    logic [jssi_pkg::NUM_W-1:0] mul_p;
    logic [jssi_pkg::NUM_W-1:0] mul_reg;

    logic [7:0]         gear_eff;
    logic signed [21:0] lo_s, hi_s, goal_s, cmd_s, last_s, meas_s;
    logic [21:0]        abs_err, step, abs_a, abs_band, abs_hi;
    logic [15:0]        tol_eff;
    logic signed [21:0] a_wrap, d_band, q_s, m_s;
    logic [21:0]        q_fb;
    logic               neg_fb;

    assign gear_eff = (cfg.gear == 8'd0) ? 8'd1 : cfg.gear;
    assign lo_s     = 22'($signed(cfg.lo));
    assign hi_s     = 22'($signed(cfg.hi));
    assign goal_s   = 22'(goal_reg);
    assign cmd_s    = 22'(cmd_reg);
    assign last_s   = 22'(last_reg);
    assign meas_s   = 22'(meas_reg);
    assign tol_eff  = (cfg.tol < jssi_pkg::TOL_FLOOR) ? jssi_pkg::TOL_FLOOR : cfg.tol;
    assign abs_err  = jssi_pkg::abs22(err_reg);
    assign step     = (abs_err < 22'(cfg.step_limit)) ? abs_err : 22'(cfg.step_limit);
    assign a_wrap   = jssi_pkg::wrap_pi(a_reg);
    assign abs_a    = jssi_pkg::abs22(a_reg);
    assign abs_hi   = jssi_pkg::abs22(a_reg - jssi_pkg::Q_TWO_PI);
    assign d_band   = last_s - a_reg;
    assign abs_band = jssi_pkg::abs22(d_band);
    assign m_s      = cfg.axneg ? -cmd_s : cmd_s;
    assign mul_p    = mul_a * mul_b;

    // feedback quotient clamp and sign
    assign q_fb   = (div_rsp.ovf || div_rsp.quo > jssi_pkg::QUO_W'(jssi_pkg::Q_SAT)) ?
                    jssi_pkg::Q_SAT : 22'(div_rsp.quo);
    assign neg_fb = neg_reg ^ (cfg.bip & ~sign_reg) ^ cfg.axneg;
    assign q_s    = neg_fb ? -$signed(q_fb) : $signed(q_fb);

    always_comb
    begin
        state_next = state_reg;
        goal_next  = goal_reg;
        cmd_next   = cmd_reg;
        last_next  = last_reg;
        meas_next  = meas_reg;
        armed_next = armed_reg;
        seen_next  = seen_reg;
        a_next     = a_reg;
        err_next   = err_reg;
        neg_next   = neg_reg;
        sign_next  = sign_reg;
        pulse_next = pulse_reg;
        dir_next   = dir_reg;
        mag_next   = mag_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        res_next   = res_reg;
        mul_a      = '0;
        mul_b      = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        div_start  = 1'b0;

        case (state_reg)
            jssi_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_item.req_type)
                        jssi_pkg::REQ_TARGET:
                        begin
                            a_next     = 22'(in_item.target);
                            state_next = jssi_pkg::ST_T_CANON;
                        end
                        jssi_pkg::REQ_FEEDBACK:
                        begin
                            neg_next   = in_item.count[31];
                            sign_next  = in_item.sign;
                            mag_next   = in_item.count[31] ? 32'(-in_item.count) :
                                                             32'(in_item.count);
                            state_next = jssi_pkg::ST_F_DEN;
                        end
                        jssi_pkg::REQ_TICK:
                        begin
                            if (armed_reg && seen_reg)
                                state_next = jssi_pkg::ST_K_ERR;
                        end
                        default:
                            state_next = jssi_pkg::ST_IDLE;
                    endcase
                end
            end

            jssi_pkg::ST_T_CANON:
            begin
                if (cfg.bip)
                    a_next = a_wrap;
                else if (hi_s <= 22'sd0 && a_reg > jssi_pkg::Q_PI)
                    a_next = a_reg - jssi_pkg::Q_TWO_PI;
                else if (lo_s >= 22'sd0 && a_reg < -jssi_pkg::Q_PI)
                    a_next = a_reg + jssi_pkg::Q_TWO_PI;
                state_next = jssi_pkg::ST_T_CHECK;
            end

            jssi_pkg::ST_T_CHECK:
            begin
                if (a_reg >= lo_s && a_reg <= hi_s)
                begin
                    goal_next  = a_reg[20:0];
                    armed_next = 1'b1;
                    if (seen_reg)
                        cmd_next = meas_reg;
                end
                else
                    armed_next = 1'b0;
                state_next = jssi_pkg::ST_IDLE;
            end

            jssi_pkg::ST_F_DEN:
            begin
                mul_a      = 32'(gear_eff);
                mul_b      = 27'(SPR);
                state_next = jssi_pkg::ST_F_MUL;
            end

            jssi_pkg::ST_F_MUL:
            begin
                den_next   = {mul_reg[23:0], 8'd0};
                mul_a      = mag_reg;
                mul_b      = jssi_pkg::TWO_PI_Q24;
                state_next = jssi_pkg::ST_F_NUM;
            end

            jssi_pkg::ST_F_NUM:
            begin
                // add half the divisor to round to nearest
                num_next   = mul_reg + jssi_pkg::NUM_W'(den_reg[jssi_pkg::DEN_W-1:1]);
                pulse_next = 1'b0;
                state_next = jssi_pkg::ST_DIV_GO;
            end

            jssi_pkg::ST_K_ERR:
            begin
                err_next   = goal_s - cmd_s;
                state_next = jssi_pkg::ST_K_MOVE;
            end

            jssi_pkg::ST_K_MOVE:
            begin
                if (abs_err <= 22'(tol_eff))
                begin
                    cmd_next   = goal_reg;
                    armed_next = 1'b0;
                end
                else if (err_reg[21])
                    cmd_next = 21'(cmd_s - $signed(step));
                else
                    cmd_next = 21'(cmd_s + $signed(step));
                state_next = jssi_pkg::ST_K_LIM;
            end

            jssi_pkg::ST_K_LIM:
            begin
                if (cmd_s >= lo_s && cmd_s <= hi_s)
                begin
                    a_next     = (m_s > jssi_pkg::A_MAX) ? jssi_pkg::A_MAX : m_s;
                    state_next = jssi_pkg::ST_K_SNAP;
                end
                else
                    state_next = jssi_pkg::ST_IDLE;
            end

            jssi_pkg::ST_K_SNAP:
            begin
                if (cfg.bip)
                begin
                    a_next = (jssi_pkg::abs22(a_wrap) <= jssi_pkg::SNAP_ZERO) ? 22'sd0 : a_wrap;
                end
                else if (abs_a <= jssi_pkg::SNAP_ZERO || abs_hi <= jssi_pkg::SNAP_ZERO)
                    a_next = 22'sd0;
                state_next = jssi_pkg::ST_K_BAND;
            end

            jssi_pkg::ST_K_BAND:
            begin
                // drop commands inside the deadband and negative unipolar ones
                if (abs_band <= jssi_pkg::SEND_BAND || (!cfg.bip && a_reg[21]))
                    state_next = jssi_pkg::ST_IDLE;
                else
                begin
                    dir_next   = cfg.bip ? (a_reg[21] ? cfg.mrev : ~cfg.mrev) : cfg.mrev;
                    last_next  = a_reg[20:0];
                    pulse_next = 1'b1;
                    mul_a      = 32'(abs_a);
                    mul_b      = 27'(gear_eff);
                    state_next = jssi_pkg::ST_P_MUL;
                end
            end

            jssi_pkg::ST_P_MUL:
            begin
                mul_a      = mul_reg[31:0];
                mul_b      = 27'(SPR);
                state_next = jssi_pkg::ST_P_NUM;
            end

            jssi_pkg::ST_P_NUM:
            begin
                num_next   = {mul_reg[jssi_pkg::NUM_W-9:0], 8'd0};
                state_next = jssi_pkg::ST_DIV_GO;
            end

            jssi_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = jssi_pkg::ST_DIV;
            end

            jssi_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (pulse_reg)
                    begin
                        res_next.kind  = jssi_pkg::KIND_CMD;
                        res_next.pulse = (div_rsp.ovf || div_rsp.quo[jssi_pkg::QUO_W-1]) ?
                                         jssi_pkg::PULSE_MAX : div_rsp.quo[23:0];
                        res_next.dir   = dir_reg;
                        res_next.angle = 21'sd0;
                    end
                    else
                    begin
                        meas_next = (q_s > jssi_pkg::A_MAX) ? jssi_pkg::A_MAX[20:0] : q_s[20:0];
                        if (!seen_reg)
                            cmd_next = meas_next;
                        seen_next      = 1'b1;
                        res_next.kind  = jssi_pkg::KIND_REPORT;
                        res_next.pulse = 24'd0;
                        res_next.dir   = 1'b0;
                        res_next.angle = meas_next;
                    end
                    state_next = jssi_pkg::ST_OUT;
                end
            end

            jssi_pkg::ST_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = jssi_pkg::ST_IDLE;
            end

            default:
                state_next = jssi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jssi_pkg::ST_IDLE;
            goal_reg  <= '0;
            cmd_reg   <= '0;
            last_reg  <= '0;
            meas_reg  <= '0;
            armed_reg <= 1'b0;
            seen_reg  <= 1'b0;
            pulse_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            goal_reg  <= goal_next;
            cmd_reg   <= cmd_next;
            last_reg  <= last_next;
            meas_reg  <= meas_next;
            armed_reg <= armed_next;
            seen_reg  <= seen_next;
            pulse_reg <= pulse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        err_reg <= err_next;
        neg_reg <= neg_next;
        sign_reg <= sign_next;
        dir_reg <= dir_next;
        mag_reg <= mag_next;
        den_reg <= den_next;
        num_reg <= num_next;
        res_reg <= res_next;
        mul_reg <= mul_p;
    end

    assign res          = res_reg;
    assign div_dividend = num_reg;
    assign div_divisor  = pulse_reg ? jssi_pkg::DEN_W'(jssi_pkg::TWO_PI_Q24) : den_reg;

endmodule

/* rtl/jssi_checker.sv */
`include "joint_setpoint_slew_interpolator_unit_assert.svh"

module jssi_checker #(
    parameter int JOINT_NUM = jssi_pkg::JOINT_NUM_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic        report_beat;
    logic        command_beat;
    logic        stalled;
    logic [2:0]  joint_field;
    logic [24:0] pulse_dir_field;
    logic [20:0] angle_field;

    assign report_beat     = m_axis_tvalid && m_axis_tuser[0];
    assign command_beat    = m_axis_tvalid && !m_axis_tuser[0];
    assign stalled         = m_axis_tvalid && !m_axis_tready;
    assign joint_field     = m_axis_tdata[2:0];
    assign pulse_dir_field = m_axis_tdata[27:3];
    assign angle_field     = m_axis_tdata[48:28];

    `JSSI_ASSERT_NOW(joint_fixed, m_axis_tvalid, joint_field == 3'(JOINT_NUM), "bad joint number")
    `JSSI_ASSERT_NOW(report_no_pulse, report_beat, pulse_dir_field == 25'd0, "pulse in a report")
    `JSSI_ASSERT_NOW(command_no_angle, command_beat, angle_field == 21'd0, "angle in a command")
    `JSSI_ASSERT_NEXT(result_held, stalled, m_axis_tvalid && $stable(m_axis_tdata), "result changed")

endmodule

bind joint_setpoint_slew_interpolator_unit jssi_checker #(
    .JOINT_NUM (JOINT_NUM)
) u_jssi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* verif/tb.sv */
module tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam longint TWO_PI_Q = 411775;
    localparam longint PI_Q = 205887;
    localparam longint TWO_PI_Q24_L = 105414357;
    localparam longint STEPS = 3200;
    localparam int JOINT = 1;

    typedef struct {
        bit                kind;
        bit [23:0]         pulse;
        bit                dir;
        bit signed [20:0]  angle;
    } motion_result_t;

    typedef struct {
        logic [1:0] req;
        int         tgt;
        int         cnt;
        bit         sgn;
        bit         typed;
        int         angle;
    } plan_row_t;

    typedef struct {
        longint gear;
        bit     mrev;
        bit     axneg;
        bit     bip;
        longint lo;
        longint hi;
        longint step_limit;
        longint tol;
    } joint_cfg_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [20:0] cfg_data;

    joint_setpoint_slew_interpolator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // joint state and settings as the block should hold them
    joint_cfg_t jc;
    longint goal_q, cmd_q, last_sent_q, meas_q;
    bit armed, fb_seen;

    motion_result_t pending_results[$];
    int errors = 0;
    int burst_left = 0;
    int rx_cycle = 0;

    // default settings: unipolar, axis reversed, limits -6.2 .. 0 rad
    plan_row_t steer_plan [21] = '{
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_FEEDBACK, 0,        0,           1'b0, 1'b1, 0},
        '{REQ_UNUSED,             5,        7,           1'b1, 1'b0, 0},
        '{jssi_pkg::REQ_TARGET,   1048575,  0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TARGET,   -1048576, 0,           1'b1, 1'b0, 0},
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TARGET,   -2000,    0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_FEEDBACK, 0,        2147483647,  1'b1, 1'b1, -1048576},
        '{jssi_pkg::REQ_FEEDBACK, 0,        -2147483648, 1'b0, 1'b1, 1048575},
        '{jssi_pkg::REQ_FEEDBACK, 0,        24000,       1'b1, 1'b0, 0},
        '{jssi_pkg::REQ_TARGET,   -406323,  0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TARGET,   0,        0,           1'b1, 1'b0, 0},
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0},
        '{jssi_pkg::REQ_TICK,     0,        0,           1'b0, 1'b0, 0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic longint abs_q(longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic longint sat_angle(longint a);
        if (a > 1048575)
            return 1048575;
        if (a < -1048576)
            return -1048576;
        return a;
    endfunction

    function automatic longint fold_pi(longint a);
        longint r;
        r = a % TWO_PI_Q;
        if (r > PI_Q)
            r -= TWO_PI_Q;
        if (r <= -PI_Q)
            r += TWO_PI_Q;
        return r;
    endfunction

    function automatic longint eff_gear();
        return jc.gear == 0 ? 1 : jc.gear;
    endfunction

    function automatic bit within_limits(longint a);
        return a >= jc.lo && a <= jc.hi;
    endfunction

    function automatic longint joint_to_pulse(longint a);
        longint p;
        p = abs_q(a) * eff_gear() * STEPS * 256 / TWO_PI_Q24_L;
        return p > 64'hFFFFFF ? 64'hFFFFFF : p;
    endfunction

    // decide whether a motor command goes out for this logical angle
    function automatic bit motor_command(longint logical, output longint pulse, output bit dir);
        longint m;
        longint c;
        pulse = 0;
        dir = 1'b0;
        if (!within_limits(logical))
            return 1'b0;
        m = sat_angle(jc.axneg ? -logical : logical);
        if (jc.bip)
        begin
            c = fold_pi(m);
            if (abs_q(c) <= 65)
                c = 0;
            if (abs_q(last_sent_q - c) <= 655)
                return 1'b0;
            dir = c < 0 ? jc.mrev : !jc.mrev;
        end
        else
        begin
            c = m;
            if (abs_q(c) <= 65 || abs_q(c - TWO_PI_Q) <= 65)
                c = 0;
            if (abs_q(last_sent_q - c) <= 655)
                return 1'b0;
            if (c < 0)
                return 1'b0;
            dir = jc.mrev;
        end
        pulse = joint_to_pulse(c);
        last_sent_q = c;
        return 1'b1;
    endfunction

    function automatic bit slew_step(logic [1:0] req, longint tgt, longint cnt, bit sgn,
                                     output motion_result_t res);
        longint a, mag, den, q, err, tol, stp, pulse;
        bit neg, dir, sent;
        res = '{default: 0};
        if (req == jssi_pkg::REQ_TARGET)
        begin
            a = tgt;
            if (jc.bip)
                a = fold_pi(a);
            else if (jc.hi <= 0 && a > PI_Q)
                a = a - TWO_PI_Q;
            else if (jc.lo >= 0 && a < -PI_Q)
                a = a + TWO_PI_Q;
            if (!within_limits(a))
            begin
                armed = 1'b0;
                return 1'b0;
            end
            goal_q = a;
            armed = 1'b1;
            if (fb_seen)
                cmd_q = meas_q;
            return 1'b0;
        end
        if (req == jssi_pkg::REQ_FEEDBACK)
        begin
            mag = abs_q(cnt);
            den = STEPS * eff_gear() * 256;
            q = (mag * TWO_PI_Q24_L + den / 2) / den;
            if (q > 1048576)
                q = 1048576;
            neg = cnt < 0;
            if (jc.bip && !sgn)
                neg = !neg;
            if (jc.axneg)
                neg = !neg;
            meas_q = sat_angle(neg ? -q : q);
            if (!fb_seen)
                cmd_q = meas_q;
            fb_seen = 1'b1;
            res.kind = jssi_pkg::KIND_REPORT;
            res.angle = meas_q[20:0];
            return 1'b1;
        end
        if (req == jssi_pkg::REQ_TICK)
        begin
            if (!armed || !fb_seen)
                return 1'b0;
            tol = jc.tol < 66 ? 66 : jc.tol;
            err = goal_q - cmd_q;
            if (abs_q(err) <= tol)
            begin
                cmd_q = goal_q;
                sent = motor_command(cmd_q, pulse, dir);
                armed = 1'b0;
            end
            else
            begin
                stp = abs_q(err) < jc.step_limit ? abs_q(err) : jc.step_limit;
                cmd_q += err < 0 ? -stp : stp;
                sent = motor_command(cmd_q, pulse, dir);
            end
            if (!sent)
                return 1'b0;
            res.kind = jssi_pkg::KIND_CMD;
            res.pulse = pulse[23:0];
            res.dir = dir;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // receiver: stall pattern cycles through free flow, random and long stalls
    always @(posedge clk)
    begin
        motion_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transfer, kind", m_axis_tuser[0], -1);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser[0] !== want.kind)
                    report_mismatch("result_kind", m_axis_tuser[0], want.kind);
                if (m_axis_tdata[2:0] !== 3'(JOINT))
                    report_mismatch("joint_number", m_axis_tdata[2:0], JOINT);
                if (m_axis_tdata[26:3] !== want.pulse)
                    report_mismatch("pulse_count", m_axis_tdata[26:3], want.pulse);
                if (m_axis_tdata[27] !== want.dir)
                    report_mismatch("motor_direction", m_axis_tdata[27], want.dir);
                if (m_axis_tdata[48:28] !== want.angle)
                    report_mismatch("reported_angle", $signed(m_axis_tdata[48:28]),
                                    want.angle);
            end
        end
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 3)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(1));
            default: m_axis_tready <= (rx_cycle % 40) < 8;
        endcase
    end

    task automatic send_item(logic [1:0] req, int tgt, int cnt, bit sgn, bit typed, int angle);
        int gap;
        motion_result_t res;
        motion_result_t typed_res;
        bit got;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {2'b00, sgn, cnt, tgt[20:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        got = slew_step(req, tgt, cnt, sgn, res);
        if (typed)
        begin
            typed_res = '{default: 0};
            typed_res.kind = jssi_pkg::KIND_REPORT;
            typed_res.angle = angle[20:0];
            pending_results = {pending_results, typed_res};
        end
        else if (got)
            pending_results = {pending_results, res};
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        // a target or a silent tick may still be in flight
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[20:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_cfg(joint_cfg_t c);
        write_reg(jssi_pkg::CFG_GEAR, c.gear);
        write_reg(jssi_pkg::CFG_MREV, c.mrev);
        write_reg(jssi_pkg::CFG_AXNEG, c.axneg);
        write_reg(jssi_pkg::CFG_BIPOLAR, c.bip);
        write_reg(jssi_pkg::CFG_LIMIT_LO, c.lo);
        write_reg(jssi_pkg::CFG_LIMIT_HI, c.hi);
        write_reg(jssi_pkg::CFG_MAX_STEP, c.step_limit);
        write_reg(jssi_pkg::CFG_TOLERANCE, c.tol);
        jc = c;
    endtask

    task automatic random_items(int n);
        int pick, tgt, cnt;
        longint span;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            tgt = 0;
            cnt = 0;
            if (pick < 60)
                send_item(jssi_pkg::REQ_TICK, $urandom, $urandom, 1'($urandom_range(1)),
                          1'b0, 0);
            else if (pick < 77)
            begin
                if ($urandom_range(3) != 0)
                    tgt = int'(jc.lo + longint'($urandom_range(32'(jc.hi - jc.lo))));
                else
                    tgt = $signed(21'($urandom));
                send_item(jssi_pkg::REQ_TARGET, tgt, $urandom, 1'($urandom_range(1)),
                          1'b0, 0);
            end
            else if (pick < 95)
            begin
                span = STEPS * eff_gear() * 2;
                if ($urandom_range(4) != 0)
                    cnt = int'(longint'($urandom_range(32'(2 * span))) - span);
                else
                    cnt = $urandom;
                send_item(jssi_pkg::REQ_FEEDBACK, $urandom, cnt, 1'($urandom_range(1)),
                          1'b0, 0);
            end
            else
                send_item(REQ_UNUSED, $urandom, $urandom, 1'($urandom_range(1)), 1'b0, 0);
        end
    endtask

    initial
    begin
        joint_cfg_t phases [6];
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        jc = '{30, 1'b0, 1'b1, 1'b0, -406323, 0, 1049, 655};
        goal_q = 0;
        cmd_q = 0;
        last_sent_q = 0;
        meas_q = 0;
        armed = 1'b0;
        fb_seen = 1'b0;
        phases[0] = '{30,  1'b1, 1'b0, 1'b1, -205887,  205887,  1049,  655};
        phases[1] = '{255, 1'b0, 1'b1, 1'b0, -406323,  0,       1049,  655};
        phases[2] = '{0,   1'b1, 1'b1, 1'b1, -1048576, 1048575, 65535, 0};
        phases[3] = '{1,   1'b0, 1'b0, 1'b0, 0,        411775,  0,     65535};
        phases[4] = '{7,   1'b1, 1'b0, 1'b0, -1048576, 1048575, 300,   66};
        phases[5] = '{100, 1'b0, 1'b1, 1'b1, -300000,  300000,  20000, 1000};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steer_plan[i])
            send_item(steer_plan[i].req, steer_plan[i].tgt, steer_plan[i].cnt,
                      steer_plan[i].sgn, steer_plan[i].typed, steer_plan[i].angle);
        random_items(130);
        foreach (phases[p])
        begin
            drain();
            apply_cfg(phases[p]);
            random_items(150);
        end
        drain();

        // every predicted result must have come out
        if (pending_results.size() != 0)
            report_mismatch("results never sent", pending_results.size(), 0);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/jssi_pkg.sv
rtl/jssi_cfg.sv
rtl/jssi_div.sv
rtl/jssi_ctrl.sv
rtl/joint_setpoint_slew_interpolator_unit.sv
rtl/jssi_checker.sv
verif/tb.sv
